>>> hdl/appd_pkg.sv
// shared types and constants for the ascii ppm pixel decoder
package appd_pkg;

    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_PIXEL  = 2'd1;
    localparam logic [1:0] KIND_FAIL   = 2'd2;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_MAGIC = 3'd1;
    localparam logic [2:0] ST_TRUNC = 3'd2;
    localparam logic [2:0] ST_NODIG = 3'd3;
    localparam logic [2:0] ST_RANGE = 3'd4;
    localparam logic [2:0] ST_DIMS  = 3'd5;

    localparam logic [2:0] PH_MAGIC  = 3'd0;
    localparam logic [2:0] PH_WIDTH  = 3'd1;
    localparam logic [2:0] PH_HEIGHT = 3'd2;
    localparam logic [2:0] PH_MAX    = 3'd3;
    localparam logic [2:0] PH_PIXELS = 3'd4;
    localparam logic [2:0] PH_DONE   = 3'd5;
    localparam logic [2:0] PH_FAILED = 3'd6;

    localparam logic [2:0] TS_BETWEEN = 3'd0;
    localparam logic [2:0] TS_LEAD    = 3'd1;
    localparam logic [2:0] TS_SIGNED  = 3'd2;
    localparam logic [2:0] TS_DIGITS  = 3'd3;
    localparam logic [2:0] TS_TRAIL   = 3'd4;

    // where a scaled channel goes
    localparam logic [1:0] DST_NONE  = 2'd0;
    localparam logic [1:0] DST_RED   = 2'd1;
    localparam logic [1:0] DST_GREEN = 2'd2;
    localparam logic [1:0] DST_BLUE  = 2'd3;

    // characters the parser reacts to
    localparam logic [7:0] ASC_SPACE = 8'h20;
    localparam logic [7:0] ASC_TAB   = 8'h09;
    localparam logic [7:0] ASC_CR    = 8'h0D;
    localparam logic [7:0] ASC_LF    = 8'h0A;
    localparam logic [7:0] ASC_VT    = 8'h0B;
    localparam logic [7:0] ASC_FF    = 8'h0C;
    localparam logic [7:0] ASC_HASH  = 8'h23;
    localparam logic [7:0] ASC_PLUS  = 8'h2B;
    localparam logic [7:0] ASC_MINUS = 8'h2D;
    localparam logic [7:0] ASC_ZERO  = 8'h30;
    localparam logic [7:0] ASC_NINE  = 8'h39;
    localparam logic [7:0] ASC_P     = 8'h50;
    localparam logic [7:0] ASC_3     = 8'h33;

    // quotient bits of the scaling divide
    localparam logic [3:0] DIV_STEPS = 4'd8;

    // one result word
    typedef struct packed {
        logic [1:0]  kind;
        logic [30:0] width;
        logic [30:0] height;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [2:0]  status;
        logic        last_pixel;
    } res_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic div_start;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic       div_pend;
        logic       div_done;
        logic [1:0] nres;
    } stat_t;

    function automatic logic is_delim(input logic [7:0] c);
        return c == ASC_SPACE || c == ASC_TAB || c == ASC_CR || c == ASC_LF
            || c == ASC_HASH;
    endfunction

endpackage

>>> hdl/appd_datapath.sv
// parse state, scaling divider and result registers
module appd_datapath
    import appd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  cmd_t        cmd,
    output stat_t       stat,
    input  logic [7:0]  byte_in,
    input  logic        end_in,
    input  logic        res_sel,
    output res_t        res_out,
    output logic        res_last
);

    logic [2:0]  phase_reg, phase_next;
    logic [1:0]  mpos_reg, mpos_next;
    logic        cmt_reg, cmt_next;
    logic [2:0]  ts_reg, ts_next;
    logic        neg_reg, neg_next;
    logic [31:0] tv_reg, tv_next;
    logic [30:0] w_reg, w_next, h_reg, h_next, max_reg, max_next;
    logic [61:0] left_reg, left_next;
    logic [1:0]  ch_reg, ch_next;
    logic [7:0]  hr_reg, hr_next, hg_reg, hg_next;
    res_t        r0_reg, r0_next, r1_reg, r1_next;
    logic [1:0]  n_reg, n_next;
    logic        pend_reg, pend_next;
    logic [1:0]  dst_reg, dst_next;
    logic [30:0] dvnd_reg, dvnd_next;
    logic [30:0] dvs_reg, dvs_next;
    // divider: restoring, one quotient bit a cycle
    logic [30:0] rem_reg;
    logic [7:0]  quo_reg;
    logic [3:0]  cnt_reg;
    logic        busy_reg, done_reg;
    logic [38:0] prod;
    logic [31:0] trial;
    logic [31:0] diff;
    logic [61:0] area;

    // value times 255 as a shift and subtract
    assign prod = {dvnd_reg, 8'd0} - {8'd0, dvnd_reg};
    assign area = 62'(w_reg) * 62'(h_reg);
    assign trial = {rem_reg, quo_reg[7]};
    assign diff = trial - {1'b0, dvs_reg};

    function automatic res_t fail_word(input logic [2:0] st);
        res_t w;
        w = '0;
        w.kind = KIND_FAIL;
        w.status = st;
        return w;
    endfunction

    // quotient fits in 8 bits since the value never exceeds the maximum
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            rem_reg  <= '0;
            quo_reg  <= '0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (cmd.div_start) begin
                busy_reg <= 1'b1;
                rem_reg  <= prod[38:8];
                quo_reg  <= prod[7:0];
                cnt_reg  <= DIV_STEPS;
            end else if (busy_reg) begin
                if (trial >= {1'b0, dvs_reg}) begin
                    rem_reg <= diff[30:0];
                    quo_reg <= {quo_reg[6:0], 1'b1};
                end else begin
                    rem_reg <= trial[30:0];
                    quo_reg <= {quo_reg[6:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 4'd1;
                if (cnt_reg == 4'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // byte parse
    always_comb begin
        logic        dig, delim, fin, hash_cmt;
        logic [35:0] v, lim;
        logic [30:0] pos, cv;
        res_t        e;
        phase_next = phase_reg; mpos_next = mpos_reg; cmt_next = cmt_reg;
        ts_next = ts_reg; neg_next = neg_reg; tv_next = tv_reg;
        w_next = w_reg; h_next = h_reg; max_next = max_reg; left_next = left_reg;
        ch_next = ch_reg; hr_next = hr_reg; hg_next = hg_reg;
        r0_next = r0_reg; r1_next = r1_reg; n_next = n_reg;
        pend_next = pend_reg; dst_next = dst_reg;
        dvnd_next = dvnd_reg; dvs_next = dvs_reg;
        e = '0;
        fin = 1'b0; hash_cmt = 1'b0;
        pos = '0; cv = '0;
        dig = byte_in >= ASC_ZERO && byte_in <= ASC_NINE;
        delim = is_delim(byte_in);
        v = 36'(tv_reg) * 36'd10 + 36'(byte_in - ASC_ZERO);
        lim = neg_reg ? 36'h0_8000_0000 : 36'h0_7FFF_FFFF;
        if (cmd.load) begin
            n_next = 2'd0;
            r0_next = '0; r1_next = '0;
            pend_next = 1'b0; dst_next = DST_NONE;
            if (phase_reg == PH_MAGIC) begin
                if (mpos_reg == 2'd0 && byte_in == ASC_P) mpos_next = 2'd1;
                else if (mpos_reg == 2'd1 && byte_in == ASC_3) mpos_next = 2'd2;
                else if (mpos_reg == 2'd2 && delim) begin
                    phase_next = PH_WIDTH;
                    cmt_next = byte_in == ASC_HASH;
                end else begin
                    phase_next = PH_FAILED; r0_next = fail_word(ST_MAGIC); n_next = 2'd1;
                end
            end else if (phase_reg >= PH_WIDTH && phase_reg <= PH_PIXELS) begin
                if (cmt_reg) begin
                    if (byte_in == ASC_LF) cmt_next = 1'b0;
                end else if (delim) begin
                    fin = ts_reg != TS_BETWEEN;
                    hash_cmt = byte_in == ASC_HASH;
                end else if (ts_reg != TS_TRAIL) begin
                    if (ts_reg == TS_BETWEEN) ts_next = TS_LEAD;
                    if (dig) begin
                        if (v > lim) begin
                            ts_next = TS_BETWEEN; neg_next = 1'b0; tv_next = '0;
                            phase_next = PH_FAILED; r0_next = fail_word(ST_RANGE);
                            n_next = 2'd1;
                        end else begin
                            tv_next = v[31:0]; ts_next = TS_DIGITS;
                        end
                    end else if (ts_reg == TS_DIGITS) ts_next = TS_TRAIL;
                    else if ((ts_reg == TS_BETWEEN || ts_reg == TS_LEAD)
                             && (byte_in == ASC_VT || byte_in == ASC_FF)) ts_next = TS_LEAD;
                    else if ((ts_reg == TS_BETWEEN || ts_reg == TS_LEAD)
                             && (byte_in == ASC_PLUS || byte_in == ASC_MINUS)) begin
                        neg_next = byte_in == ASC_MINUS; ts_next = TS_SIGNED;
                    end else begin
                        ts_next = TS_BETWEEN; neg_next = 1'b0; tv_next = '0;
                        phase_next = PH_FAILED; r0_next = fail_word(ST_NODIG);
                        n_next = 2'd1;
                    end
                end
            end
            // an open token also ends at the end of the data
            if (end_in && phase_next >= PH_WIDTH && phase_next <= PH_PIXELS
                && ts_next != TS_BETWEEN) fin = 1'b1;
            // token end: store a dimension or a channel
            if (fin) begin
                if (ts_next == TS_LEAD || ts_next == TS_SIGNED) begin
                    phase_next = PH_FAILED; r0_next = fail_word(ST_NODIG); n_next = 2'd1;
                end else begin
                    pos = neg_next ? 31'd0 : tv_next[30:0];
                    if (phase_next == PH_WIDTH) begin
                        w_next = pos; phase_next = PH_HEIGHT;
                    end else if (phase_next == PH_HEIGHT) begin
                        h_next = pos; phase_next = PH_MAX;
                    end else if (phase_next == PH_MAX) begin
                        max_next = pos;
                        if (w_reg == '0 || h_reg == '0 || pos == '0) begin
                            phase_next = PH_FAILED; r0_next = fail_word(ST_DIMS);
                        end else begin
                            e.kind = KIND_HEADER; e.width = w_reg; e.height = h_reg;
                            left_next = area; ch_next = 2'd0; phase_next = PH_PIXELS;
                            r0_next = e;
                        end
                        n_next = 2'd1;
                    end else if (phase_next == PH_PIXELS && max_reg != '0) begin
                        // clamp and hand the channel to the divider
                        cv = (pos > max_reg) ? max_reg : pos;
                        dvnd_next = cv; dvs_next = max_reg; pend_next = 1'b1;
                        if (ch_reg == 2'd0) begin
                            dst_next = DST_RED; ch_next = 2'd1;
                        end else if (ch_reg == 2'd1) begin
                            dst_next = DST_GREEN; ch_next = 2'd2;
                        end else begin
                            dst_next = DST_BLUE; ch_next = 2'd0;
                            if (left_reg != '0) left_next = left_reg - 62'd1;
                            e.kind = KIND_PIXEL; e.red = hr_reg; e.green = hg_reg;
                            e.last_pixel = left_reg <= 62'd1;
                            if (left_reg <= 62'd1) phase_next = PH_DONE;
                            r0_next = e; n_next = 2'd1;
                        end
                    end
                end
                ts_next = TS_BETWEEN; neg_next = 1'b0; tv_next = '0;
            end
            if (hash_cmt && phase_next >= PH_WIDTH && phase_next <= PH_PIXELS)
                cmt_next = 1'b1;
            // end of data: truncation check and restart
            if (end_in) begin
                if (phase_next == PH_MAGIC) begin
                    r0_next = fail_word((mpos_next == 2'd2) ? ST_TRUNC : ST_MAGIC);
                    n_next = 2'd1;
                end else if (phase_next >= PH_WIDTH && phase_next <= PH_PIXELS) begin
                    if (n_next == 2'd0) r0_next = fail_word(ST_TRUNC);
                    else r1_next = fail_word(ST_TRUNC);
                    n_next = n_next + 2'd1;
                end
                phase_next = PH_MAGIC; mpos_next = 2'd0; cmt_next = 1'b0;
                ts_next = TS_BETWEEN; neg_next = 1'b0; tv_next = '0;
                w_next = '0; h_next = '0; max_next = '0; left_next = '0;
                ch_next = 2'd0; hr_next = '0; hg_next = '0;
                // a held red or green channel is dropped with the restart; a blue one is kept
                if (dst_next != DST_BLUE) begin
                    pend_next = 1'b0; dst_next = DST_NONE;
                end
            end
        end else if (cmd.div_start) begin
            pend_next = 1'b0;
        end else if (done_reg) begin
            // scaled channel ready
            case (dst_reg)
                DST_RED:   hr_next = quo_reg;
                DST_GREEN: hg_next = quo_reg;
                DST_BLUE:  r0_next.blue = quo_reg;
                default:   dst_next = DST_NONE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_MAGIC; mpos_reg <= '0; cmt_reg <= 1'b0;
            ts_reg <= TS_BETWEEN; neg_reg <= 1'b0; tv_reg <= '0;
            w_reg <= '0; h_reg <= '0; max_reg <= '0; left_reg <= '0;
            ch_reg <= '0; hr_reg <= '0; hg_reg <= '0;
            r0_reg <= '0; r1_reg <= '0; n_reg <= '0;
            pend_reg <= 1'b0; dst_reg <= DST_NONE; dvnd_reg <= '0; dvs_reg <= '0;
        end else begin
            phase_reg <= phase_next; mpos_reg <= mpos_next; cmt_reg <= cmt_next;
            ts_reg <= ts_next; neg_reg <= neg_next; tv_reg <= tv_next;
            w_reg <= w_next; h_reg <= h_next; max_reg <= max_next;
            left_reg <= left_next; ch_reg <= ch_next; hr_reg <= hr_next;
            hg_reg <= hg_next; r0_reg <= r0_next; r1_reg <= r1_next; n_reg <= n_next;
            pend_reg <= pend_next; dst_reg <= dst_next;
            dvnd_reg <= dvnd_next; dvs_reg <= dvs_next;
        end
    end

    assign stat.div_pend = pend_reg;
    assign stat.div_done = done_reg;
    assign stat.nres = n_reg;
    // results leave in order: first word, then second
    assign res_out = res_sel ? r1_reg : r0_reg;
    assign res_last = res_sel || (n_reg == 2'd1);

endmodule

>>> hdl/appd_control.sv
// sequencing of input acceptance, scaling and result delivery
module appd_control
    import appd_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    output logic  m_valid,
    input  logic  m_ready,
    output cmd_t  cmd,
    input  stat_t stat,
    output logic  res_sel
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EVAL = 5'b00010,
        S_DIV  = 5'b00100,
        S_OUT0 = 5'b01000,
        S_OUT1 = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    assign s_ready = state_reg == S_IDLE;
    assign m_valid = state_reg == S_OUT0 || state_reg == S_OUT1;
    assign res_sel = state_reg == S_OUT1;
    assign cmd.load = s_valid && s_ready;
    assign cmd.div_start = state_reg == S_EVAL && stat.div_pend;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (cmd.load) state_next = S_EVAL;
            S_EVAL: begin
                if (stat.div_pend) state_next = S_DIV;
                else state_next = (stat.nres != 2'd0) ? S_OUT0 : S_IDLE;
            end
            S_DIV: begin
                if (stat.div_done)
                    state_next = (stat.nres != 2'd0) ? S_OUT0 : S_IDLE;
            end
            S_OUT0: if (m_ready) state_next = (stat.nres == 2'd2) ? S_OUT1 : S_IDLE;
            S_OUT1: if (m_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= S_IDLE;
        else state_reg <= state_next;
    end

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid)) else $error("input taken while output pending");
    a_out_after: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT1) |-> $past(state_reg == S_OUT0 || state_reg == S_OUT1))
        else $error("second word without first");
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid) else $error("output word dropped");
    a_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg)) else $error("state not one-hot");
`endif

endmodule

>>> hdl/ascii_ppm_pixel_decoder_unit.sv
// ascii ppm (p3) decoder: one byte in, up to two words out
// a taken byte goes through the evaluate state, then the divide state when a channel is scaled, to the word states
// a new byte is taken only in the idle state, once all words for the last byte are out
// the scaling time is set by the eight-step restoring divider
// aresetn synchronous active low: parse state returns to expecting the magic
module ascii_ppm_pixel_decoder_unit
    import appd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_byte_req,
    input  logic        s_end_of_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [30:0] m_width,
    output logic [30:0] m_height,
    output logic [7:0]  m_red,
    output logic [7:0]  m_green,
    output logic [7:0]  m_blue,
    output logic [7:0]  m_alpha,
    output logic [2:0]  m_status,
    output logic        m_last_pixel,
    output logic        m_last
);

    cmd_t  cmd;
    stat_t stat;
    res_t  res;
    logic  res_sel;

    appd_control u_ctl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready), .cmd(cmd), .stat(stat),
        .res_sel(res_sel)
    );

    appd_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .stat(stat),
        .byte_in(s_byte_req), .end_in(s_end_of_data), .res_sel(res_sel),
        .res_out(res), .res_last(m_last)
    );

    assign m_kind = res.kind;
    assign m_width = res.width;
    assign m_height = res.height;
    assign m_red = res.red;
    assign m_green = res.green;
    assign m_blue = res.blue;
    assign m_alpha = (res.kind == KIND_PIXEL) ? 8'd255 : 8'd0;
    assign m_status = res.status;
    assign m_last_pixel = res.last_pixel;

endmodule

>>> test/tb_ascii_ppm_pixel_decoder_unit.sv
// testbench for the ascii ppm pixel decoder: byte stream in, decoded words checked
`timescale 1ns / 1ps

module tb_ascii_ppm_pixel_decoder_unit;
    import appd_pkg::*;

    // characters the parser reacts to
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_3     = 8'h33;

    localparam int TARGET_BYTES = 550;

    typedef struct {
        logic [1:0]  kind;
        logic [30:0] width;
        logic [30:0] height;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [2:0]  status;
        logic        last_pixel;
        logic        last;
    } ppm_word_t;

    typedef logic [7:0] file_bytes_t[$];

    // decoder model plus queue of words still owed by the block
    class ppm_scoreboard;
        ppm_word_t pending_words[$];
        ppm_word_t byte_words[$];
        int        errors;
        logic [2:0]  phase;
        logic [1:0]  magic_pos;
        logic        in_cmt;
        logic [2:0]  tok_stage;
        logic        tok_neg;
        logic [31:0] tok_val;
        logic [30:0] img_w, img_h, max_val;
        logic [63:0] px_left;
        logic [1:0]  chan;
        logic [7:0]  hold_r, hold_g;

        function new();
            errors = 0;
            clear_parse();
        endfunction

        function void clear_token();
            tok_stage = TS_BETWEEN;
            tok_neg = 1'b0;
            tok_val = '0;
        endfunction

        function void clear_parse();
            phase = PH_MAGIC;
            magic_pos = '0;
            in_cmt = 1'b0;
            clear_token();
            img_w = '0;
            img_h = '0;
            max_val = '0;
            px_left = '0;
            chan = '0;
            hold_r = '0;
            hold_g = '0;
        endfunction

        function bit is_sep(logic [7:0] c);
            return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF || c == CH_HASH;
        endfunction

        function void emit(logic [1:0] k, logic [30:0] w, logic [30:0] h, logic [7:0] r,
                           logic [7:0] g, logic [7:0] b, logic [7:0] a, logic [2:0] st,
                           logic lp);
            ppm_word_t wd;
            wd = '{k, w, h, r, g, b, a, st, lp, 1'b0};
            byte_words.push_back(wd);
        endfunction

        function void fail(logic [2:0] st);
            phase = PH_FAILED;
            emit(KIND_FAIL, 0, 0, 0, 0, 0, 0, st, 0);
        endfunction

        // a token just ended: store a dimension or a channel
        function void end_token();
            logic [30:0] pos;
            logic [63:0] v, sc;
            if (tok_stage == TS_LEAD || tok_stage == TS_SIGNED) begin
                clear_token();
                fail(ST_NODIG);
                return;
            end
            pos = tok_neg ? 31'd0 : tok_val[30:0];
            if (phase == PH_WIDTH) begin
                img_w = pos;
                phase = PH_HEIGHT;
            end else if (phase == PH_HEIGHT) begin
                img_h = pos;
                phase = PH_MAX;
            end else if (phase == PH_MAX) begin
                max_val = pos;
                if (img_w == 0 || img_h == 0 || max_val == 0) begin
                    fail(ST_DIMS);
                end else begin
                    px_left = 64'(img_w) * 64'(img_h);
                    chan = 0;
                    phase = PH_PIXELS;
                    emit(KIND_HEADER, img_w, img_h, 0, 0, 0, 0, ST_OK, 0);
                end
            end else if (phase == PH_PIXELS && max_val != 0) begin
                v = (pos > max_val) ? 64'(max_val) : 64'(pos);
                sc = (v * 64'd255) / 64'(max_val);
                if (chan == 0) begin
                    hold_r = sc[7:0];
                    chan = 1;
                end else if (chan == 1) begin
                    hold_g = sc[7:0];
                    chan = 2;
                end else begin
                    chan = 0;
                    if (px_left != 0) px_left--;
                    if (px_left == 0) phase = PH_DONE;
                    emit(KIND_PIXEL, 0, 0, hold_r, hold_g, sc[7:0], 8'd255, ST_OK,
                         px_left == 0);
                end
            end
            clear_token();
        endfunction

        // a non-separator byte inside the number area
        function void token_byte(logic [7:0] c);
            logic [63:0] lim, v;
            if (tok_stage == TS_BETWEEN) tok_stage = TS_LEAD;
            if (tok_stage == TS_TRAIL) return;
            if (c >= CH_ZERO && c <= CH_NINE) begin
                lim = tok_neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
                v = 64'(tok_val) * 64'd10 + 64'(c - CH_ZERO);
                if (v > lim) begin
                    clear_token();
                    fail(ST_RANGE);
                    return;
                end
                tok_val = v[31:0];
                tok_stage = TS_DIGITS;
                return;
            end
            if (tok_stage == TS_DIGITS) begin
                tok_stage = TS_TRAIL;
                return;
            end
            if (tok_stage == TS_LEAD) begin
                if (c == CH_VT || c == CH_FF) return;
                if (c == CH_PLUS || c == CH_MINUS) begin
                    tok_neg = (c == CH_MINUS);
                    tok_stage = TS_SIGNED;
                    return;
                end
            end
            clear_token();
            fail(ST_NODIG);
        endfunction

        // accepted input word: queue the words it causes
        function void note_byte(logic [7:0] c, logic eod);
            byte_words.delete();
            if (phase == PH_MAGIC) begin
                if (magic_pos == 0) begin
                    if (c == CH_P) magic_pos = 1;
                    else fail(ST_MAGIC);
                end else if (magic_pos == 1) begin
                    if (c == CH_3) magic_pos = 2;
                    else fail(ST_MAGIC);
                end else if (is_sep(c)) begin
                    phase = PH_WIDTH;
                    if (c == CH_HASH) in_cmt = 1'b1;
                end else begin
                    fail(ST_MAGIC);
                end
            end else if (phase >= PH_WIDTH && phase <= PH_PIXELS) begin
                if (in_cmt) begin
                    if (c == CH_LF) in_cmt = 1'b0;
                end else if (is_sep(c)) begin
                    if (tok_stage != TS_BETWEEN) end_token();
                    if (c == CH_HASH && phase >= PH_WIDTH && phase <= PH_PIXELS) in_cmt = 1'b1;
                end else begin
                    token_byte(c);
                end
            end
            // end of file: flush the open token, then report missing data
            if (eod) begin
                if (phase == PH_MAGIC) begin
                    fail(magic_pos == 2 ? ST_TRUNC : ST_MAGIC);
                end else if (phase >= PH_WIDTH && phase <= PH_PIXELS) begin
                    if (tok_stage != TS_BETWEEN) end_token();
                    if (phase >= PH_WIDTH && phase <= PH_PIXELS) fail(ST_TRUNC);
                end
                clear_parse();
            end
            if (byte_words.size() > 0) byte_words[byte_words.size() - 1].last = 1'b1;
            foreach (byte_words[i]) pending_words.push_back(byte_words[i]);
        endfunction

        function void cmp(string name, longint exp_v, longint got_v);
            if (exp_v != got_v) begin
                $error("%s: expected %0d, got %0d", name, exp_v, got_v);
                errors++;
            end
        endfunction

        // output word accepted: compare with the oldest expected word
        function void check_word(ppm_word_t got);
            ppm_word_t e;
            if (pending_words.size() == 0) begin
                $error("unexpected output word, kind %0d", got.kind);
                errors++;
                return;
            end
            e = pending_words.pop_front();
            cmp("kind", e.kind, got.kind);
            cmp("width", e.width, got.width);
            cmp("height", e.height, got.height);
            cmp("red", e.red, got.red);
            cmp("green", e.green, got.green);
            cmp("blue", e.blue, got.blue);
            cmp("alpha", e.alpha, got.alpha);
            cmp("status", e.status, got.status);
            cmp("last_pixel", e.last_pixel, got.last_pixel);
            cmp("last", e.last, got.last);
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_byte_req;
    logic        s_end_of_data;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_kind;
    logic [30:0] m_width;
    logic [30:0] m_height;
    logic [7:0]  m_red;
    logic [7:0]  m_green;
    logic [7:0]  m_blue;
    logic [7:0]  m_alpha;
    logic [2:0]  m_status;
    logic        m_last_pixel;
    logic        m_last;

    ppm_scoreboard sb = new();
    bit idle_on = 1'b1;
    bit hold_req = 1'b0;
    int bytes_sent = 0;

    ascii_ppm_pixel_decoder_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_byte_req(s_byte_req), .s_end_of_data(s_end_of_data),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_kind(m_kind), .m_width(m_width), .m_height(m_height),
        .m_red(m_red), .m_green(m_green), .m_blue(m_blue), .m_alpha(m_alpha),
        .m_status(m_status), .m_last_pixel(m_last_pixel), .m_last(m_last)
    );

    // clock
    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // run limit
    initial begin
        #5ms;
        $display("** ascii_ppm_pixel_decoder_unit: FAILED **");
        $finish;
    end

    // output monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_word('{m_kind, m_width, m_height, m_red, m_green, m_blue, m_alpha,
                            m_status, m_last_pixel, m_last});
    end

    // receiver: random stalls plus one long hold-off on request
    initial begin
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (300) @(posedge aclk);
                hold_req = 1'b0;
                m_ready <= 1'b1;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // send one word and wait for it to be taken
    task automatic send_byte(logic [7:0] b, logic eod);
        s_valid <= 1'b1;
        s_byte_req <= b;
        s_end_of_data <= eod;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_byte(b, eod);
        bytes_sent++;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
    endtask

    task automatic send_file(file_bytes_t f);
        foreach (f[i]) send_byte(f[i], i == f.size() - 1);
    endtask

    task automatic add_str(ref file_bytes_t f, input string s);
        for (int i = 0; i < s.len(); i++) f.push_back(s[i]);
    endtask

    // random separator, sometimes a comment with arbitrary bytes
    task automatic add_sep(ref file_bytes_t f);
        int n;
        case ($urandom_range(0, 6))
            0: f.push_back(CH_TAB);
            1: f.push_back(CH_CR);
            2: f.push_back(CH_LF);
            3: begin
                f.push_back(CH_HASH);
                n = $urandom_range(0, 4);
                repeat (n) f.push_back(8'($urandom_range(11, 255)));
                f.push_back(CH_LF);
            end
            default: f.push_back(CH_SPACE);
        endcase
    endtask

    // number token, occasionally malformed
    task automatic add_num(ref file_bytes_t f, input longint v);
        case ($urandom_range(0, 19))
            0: add_str(f, $sformatf("-%0d", v));
            1: add_str(f, $sformatf("+%0d", v));
            2: add_str(f, $sformatf("%0dz", v));
            3: add_str(f, $sformatf("\v%0d", v));
            4: if ($urandom_range(0, 3) == 0) add_str(f, "99999999999");
               else add_str(f, $sformatf("%0d", v));
            5: if ($urandom_range(0, 3) == 0) add_str(f, "-x");
               else add_str(f, $sformatf("%0d", v));
            default: add_str(f, $sformatf("%0d", v));
        endcase
    endtask

    // mostly well-formed small images with random content
    task automatic gen_file(ref file_bytes_t f);
        longint w, h, mx, v;
        int cut;
        f.delete();
        if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(3, 12)) f.push_back(8'($urandom_range(0, 255)));
            return;
        end
        w = $urandom_range(1, 3);
        h = $urandom_range(1, 2);
        if ($urandom_range(0, 11) == 0) w = 0;
        case ($urandom_range(0, 4))
            0: mx = 1;
            1: mx = 255;
            2: mx = 64'h7FFF_FFFF;
            default: mx = $urandom_range(2, 70000);
        endcase
        add_str(f, "P3");
        add_sep(f);
        add_num(f, w);
        add_sep(f);
        add_num(f, h);
        add_sep(f);
        add_num(f, mx);
        add_sep(f);
        for (int i = 0; i < w * h * 3; i++) begin
            case ($urandom_range(0, 5))
                0: v = 0;
                1: v = mx;
                2: v = mx + $urandom_range(1, 1000);
                default: v = longint'($urandom) % (mx + 1);
            endcase
            if (v > 64'h7FFF_FFFF) v = 64'h7FFF_FFFF;
            add_num(f, v);
            if (i != w * h * 3 - 1 || $urandom_range(0, 1) == 0) add_sep(f);
        end
        if ($urandom_range(0, 5) == 0) begin
            cut = $urandom_range(1, f.size() - 1);
            while (f.size() > cut) void'(f.pop_back());
        end
        if ($urandom_range(0, 6) == 0) add_str(f, " 1 2 junk");
    endtask

    // main stimulus
    initial begin
        file_bytes_t f;
        int nfile;
        s_valid <= 1'b0;
        s_byte_req <= '0;
        s_end_of_data <= 1'b0;
        aresetn <= 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: magic errors, truncation, dims, range, comments, sign and junk
        f = {}; add_str(f, "X"); send_file(f);
        f = {}; add_str(f, "P"); send_file(f);
        f = {}; add_str(f, "P3"); send_file(f);
        f = {}; add_str(f, "P4"); send_file(f);
        f = {}; add_str(f, "P3#c\n1 1 1\n1 0 +1"); send_file(f);
        f = {}; add_str(f, "P3 0 1 5 "); send_file(f);
        f = {}; add_str(f, "P3 1 1 -2147483648 "); send_file(f);
        f = {}; add_str(f, "P3 1 1 2147483647 2147483648"); send_file(f);
        f = {}; add_str(f, "P3\t1 1 7x\v-3 9 4# "); send_file(f);

        // random files
        nfile = 0;
        while (bytes_sent < TARGET_BYTES) begin
            gen_file(f);
            if (f.size() == 0) continue;
            if (nfile == 3) hold_req = 1'b1;
            if (nfile == 6) begin
                s_valid <= 1'b0;
                @(posedge aclk);
                while (sb.pending_words.size() != 0) @(posedge aclk);
            end
            if (bytes_sent > TARGET_BYTES * 4 / 5) idle_on = 1'b0;
            send_file(f);
            nfile++;
        end
        s_valid <= 1'b0;

        // drain, then watch for stray words
        while (sb.pending_words.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (sb.errors == 0 && sb.pending_words.size() == 0)
            $display("** ascii_ppm_pixel_decoder_unit: PASSED **");
        else
            $display("** ascii_ppm_pixel_decoder_unit: FAILED **");
        $finish;
    end

endmodule
